// File: sv/pcm_scm_pkg.sv
package pcm_scm_pkg;

    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned VOL_W    = 8;
    localparam int unsigned FMT_W    = 2;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_S32 = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_FORMAT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FORMAT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_PERCENT = 2'd2;

    localparam logic [FMT_W-1:0] RST_SOURCE_FORMAT  = FMT_S16;
    localparam logic [FMT_W-1:0] RST_TARGET_FORMAT  = FMT_S16;
    localparam logic [VOL_W-1:0] RST_VOLUME_PERCENT = 8'd100;

    // Unsigned divide by 100 of any 32-bit value: (x * RECIP_100) >> RECIP_SHIFT.
    localparam logic [31:0] RECIP_100   = 32'h51EB_851F;
    localparam int unsigned RECIP_SHIFT = 37;
    localparam int unsigned QUOT_W      = 64 - RECIP_SHIFT;

    localparam logic [7:0]  U8_MAX  = 8'hff;
    localparam logic [7:0]  HALF_LSB = 8'h80;
    localparam logic signed [33:0] S16_MAX = 34'sh0_7fff;
    localparam logic signed [33:0] S16_MIN = -34'sh0_8000;

endpackage

// File: sv/pcm_sample_convert_mix_unit.sv
// Mixes one source PCM sample, scaled by a volume percentage, into one destination
// sample and returns the sum in the destination format (8-bit clamps at 255, 16-bit
// saturates, 32-bit wraps). Each input word carries source_raw in bits 31:0 and
// target_raw in bits 63:32; each output word carries mixed_raw. The datapath is a
// four-stage pipeline (volume multiply, reciprocal multiply for the divide by 100,
// sign restore and width conversion, mix and clamp), so one word is accepted every
// cycle unless the output stalls, and the result is presented from the mix and
// clamp stage register. Formats and volume are read live by the pipeline stages,
// so they should only be written while the pipeline is empty.
module pcm_sample_convert_mix_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // source_raw[31:0], target_raw[63:32]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // mixed_raw[31:0]
);

    logic [pcm_scm_pkg::FMT_W-1:0] r_src_fmt;
    logic [pcm_scm_pkg::FMT_W-1:0] r_tgt_fmt;
    logic [pcm_scm_pkg::VOL_W-1:0] r_vol;

    logic        r_v1, r_v2, r_v3, r_v4;
    logic        w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    logic [31:0] r_prod;
    logic [31:0] r_traw1, r_traw2, r_traw3;
    logic [63:0] r_recip;
    logic        r_neg;
    logic [31:0] r_q;
    logic [31:0] r_mixed;

    logic [31:0] n_prod;
    logic [31:0] n_src;
    logic [31:0] w_mag;
    logic [63:0] n_recip;
    logic [31:0] w_quot;
    logic [31:0] w_qs;
    logic [31:0] n_q;
    logic [7:0]  w_hi;
    logic [31:0] w_sum32;
    logic signed [33:0] w_sum34;
    logic [31:0] n_mixed;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt <= pcm_scm_pkg::RST_SOURCE_FORMAT;
            r_tgt_fmt <= pcm_scm_pkg::RST_TARGET_FORMAT;
            r_vol     <= pcm_scm_pkg::RST_VOLUME_PERCENT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pcm_scm_pkg::CFG_SOURCE_FORMAT:  r_src_fmt <= i_cfg_data[1:0];
                pcm_scm_pkg::CFG_TARGET_FORMAT:  r_tgt_fmt <= i_cfg_data[1:0];
                pcm_scm_pkg::CFG_VOLUME_PERCENT: r_vol     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_rdy4 = !r_v4 || i_m_tready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_s_tready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_s_tvalid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    always_comb begin
        case (r_src_fmt)
            pcm_scm_pkg::FMT_U8:  n_src = {24'd0, i_s_tdata[7:0]};
            pcm_scm_pkg::FMT_S16: n_src = {{16{i_s_tdata[15]}}, i_s_tdata[15:0]};
            default:              n_src = i_s_tdata[31:0];
        endcase
        n_prod = n_src * {24'd0, r_vol};
    end

    assign w_mag   = r_prod[31] ? (~r_prod + 32'd1) : r_prod;
    assign n_recip = {32'd0, w_mag} * {32'd0, pcm_scm_pkg::RECIP_100};

    always_comb begin
        w_quot = {{(32 - pcm_scm_pkg::QUOT_W){1'b0}}, r_recip[63:pcm_scm_pkg::RECIP_SHIFT]};
        w_qs   = r_neg ? (~w_quot + 32'd1) : w_quot;
        w_hi   = w_qs[15:8];
        if (r_src_fmt == pcm_scm_pkg::FMT_S16 && r_tgt_fmt == pcm_scm_pkg::FMT_U8) begin
            if (w_hi != pcm_scm_pkg::U8_MAX && w_qs[7:0] > pcm_scm_pkg::HALF_LSB) begin
                n_q = {24'd0, w_hi + 8'd1};
            end else begin
                n_q = {24'd0, w_hi};
            end
        end else if (r_src_fmt == pcm_scm_pkg::FMT_U8 && r_tgt_fmt == pcm_scm_pkg::FMT_S16) begin
            n_q = {16'd0, {8{w_qs[7]}}, w_qs[7:0]};
        end else begin
            n_q = w_qs;
        end
    end

    always_comb begin
        w_sum32 = 32'd0;
        w_sum34 = 34'sd0;
        case (r_tgt_fmt)
            pcm_scm_pkg::FMT_U8: begin
                w_sum32 = {24'd0, r_traw3[7:0]} + r_q;
                n_mixed = (w_sum32 > {24'd0, pcm_scm_pkg::U8_MAX}) ?
                          {24'd0, pcm_scm_pkg::U8_MAX} : w_sum32;
            end
            pcm_scm_pkg::FMT_S16: begin
                w_sum34 = $signed({{18{r_traw3[15]}}, r_traw3[15:0]})
                        + $signed({{2{r_q[31]}}, r_q});
                if (w_sum34 > pcm_scm_pkg::S16_MAX) begin
                    n_mixed = {16'd0, pcm_scm_pkg::S16_MAX[15:0]};
                end else if (w_sum34 < pcm_scm_pkg::S16_MIN) begin
                    n_mixed = {16'd0, pcm_scm_pkg::S16_MIN[15:0]};
                end else begin
                    n_mixed = {16'd0, w_sum34[15:0]};
                end
            end
            default: n_mixed = r_traw3 + r_q;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_s_tvalid) begin
            r_prod  <= n_prod;
            r_traw1 <= i_s_tdata[63:32];
        end
        if (w_rdy2 && r_v1) begin
            r_recip <= n_recip;
            r_neg   <= r_prod[31];
            r_traw2 <= r_traw1;
        end
        if (w_rdy3 && r_v2) begin
            r_q     <= n_q;
            r_traw3 <= r_traw2;
        end
        if (w_rdy4 && r_v3) begin
            r_mixed <= n_mixed;
        end
    end

    assign o_m_tvalid = r_v4;
    assign o_m_tdata  = r_mixed;

endmodule

// File: sv/pcm_scm_checker.sv
module pcm_scm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("Stalled output word changed or was dropped.");

    a_fall_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_m_tvalid) |-> $past(i_m_tready))
        else $error("Output valid fell without a handshake.");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("Input refused while the output is empty.");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) ##1 i_m_tready ##1 i_m_tready ##1 i_m_tready
        |=> o_m_tvalid)
        else $error("Accepted word did not reach the output in four cycles.");

endmodule

bind pcm_sample_convert_mix_unit pcm_scm_checker u_pcm_scm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
